// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds whenever trig holds, out of reset.
`define TPS_ASSERT_IMPL(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// Check that cond holds in the cycle after trig.
`define TPS_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// ===== hdl/tps_pkg.sv =====
// Types and constants of the two-slot priority job scheduler.
package tps_pkg;

  localparam int ID_W     = 8;
  localparam int NEED_W   = 12;
  localparam int PRIO_W   = 8;
  localparam int ARR_W    = 12;
  localparam int TIME_W   = 16;
  localparam int SUM_W    = 17;
  localparam int Q_W      = 10;
  localparam int RECIP    = 83887;
  localparam int RECIP_SH = 23;
  localparam int PROD_W   = 34;
  localparam int MIN_LIM  = 60;
  localparam int HOUR_FIX = 40;
  localparam int BASE     = 100;
  localparam logic [TIME_W-1:0] CLK_START = 16'd2400;
  localparam logic [TIME_W-1:0] TIME_MAX  = 16'hFFFF;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [NEED_W-1:0] need;
    logic [PRIO_W-1:0] prio;
    logic [ARR_W-1:0]  arrive;
  } job_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_TAKE_L,
    CELL_TAKE_R
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_REFILL,
    S_SUM,
    S_QUOT,
    S_FIX
  } tps_state_t;

endpackage

// ===== hdl/tps_in_if.sv =====
// Input and result channel interfaces of the scheduler.
interface tps_in_if;
  import tps_pkg::*;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ID_W-1:0]   job_id;
  logic [NEED_W-1:0] run_time;
  logic [PRIO_W-1:0] priority_req;
  logic [ARR_W-1:0]  arrival_time;
  modport source (output valid, opcode, job_id, run_time, priority_req, arrival_time,
                  input ready);
  modport sink (input valid, opcode, job_id, run_time, priority_req, arrival_time,
                output ready);
endinterface

interface tps_out_if #(parameter int CNT_W = 5);
  import tps_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] now_time;
  logic              running_valid;
  logic [ID_W-1:0]   running_id;
  logic [TIME_W-1:0] running_elapsed;
  logic              finished;
  logic              ready_valid;
  logic [ID_W-1:0]   ready_id;
  logic [CNT_W-1:0]  backup_count;
  logic [CNT_W-1:0]  pending_count;
  logic              all_done;
  modport source (output valid, now_time, running_valid, running_id, running_elapsed,
                  finished, ready_valid, ready_id, backup_count, pending_count, all_done,
                  input ready);
  modport sink (input valid, now_time, running_valid, running_id, running_elapsed,
                finished, ready_valid, ready_id, backup_count, pending_count, all_done,
                output ready);
endinterface

// ===== hdl/tps_cell.sv =====
// One table cell: holds a job, loads a new one or takes a neighbor's.
module tps_cell import tps_pkg::*; (
  input  logic     clk,
  input  cell_op_t op,
  input  job_t     new_job,
  input  job_t     left,
  input  job_t     right,
  output job_t     q
);

  always_ff @(posedge clk) begin
    case (op)
      CELL_LOAD:   q <= new_job;
      CELL_TAKE_L: q <= left;
      CELL_TAKE_R: q <= right;
      default:     q <= q;
    endcase
  end

endmodule

// ===== hdl/tps_chain.sv =====
// Sorted job table built as a row of cells with sorted insert and delete-at-index.
module tps_chain import tps_pkg::*; #(
  parameter int DEPTH   = 16,
  parameter bit BY_PRIO = 1'b1,
  parameter int CW      = $clog2(DEPTH + 1),
  parameter int IW      = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          ins,
  input  job_t          ins_job,
  input  logic          del,
  input  logic [IW-1:0] del_idx,
  input  logic [IW-1:0] rd_idx,
  output job_t          rd_job,
  output logic [CW-1:0] count,
  output logic          full
);

  job_t     cells [DEPTH];
  logic     shift_up [DEPTH];
  cell_op_t ops [DEPTH];

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic occ;
      logic gt;
      logic prev_shift;
      job_t left_job;
      job_t right_job;

      assign occ = CW'(g) < count;
      assign gt  = BY_PRIO ?
                   ((cells[g].prio > ins_job.prio) ||
                    ((cells[g].prio == ins_job.prio) && (cells[g].need > ins_job.need))) :
                   (cells[g].need > ins_job.need);
      assign shift_up[g] = occ && gt;

      if (g == 0) begin : g_first
        assign prev_shift = 1'b0;
        assign left_job   = cells[g];
      end else begin : g_mid
        assign prev_shift = shift_up[g-1];
        assign left_job   = cells[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
        assign right_job = cells[g];
      end else begin : g_notlast
        assign right_job = cells[g+1];
      end

      always_comb begin
        ops[g] = CELL_HOLD;
        if (ins) begin
          if (prev_shift) begin
            ops[g] = CELL_TAKE_L;
          end else if (shift_up[g] || (CW'(g) == count)) begin
            ops[g] = CELL_LOAD;
          end
        end else if (del && (IW'(g) >= del_idx) && (g < DEPTH - 1)) begin
          ops[g] = CELL_TAKE_R;
        end
      end

      tps_cell u_cell (
        .clk     (clk),
        .op      (ops[g]),
        .new_job (ins_job),
        .left    (left_job),
        .right   (right_job),
        .q       (cells[g])
      );
    end
  endgenerate

  assign rd_job = cells[rd_idx];
  assign full   = count == CW'(DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ins && !del) begin
      count <= count + CW'(1);
    end else if (del && !ins) begin
      count <= count - CW'(1);
    end
  end

endmodule

// ===== hdl/two_slot_priority_job_scheduler.sv =====
// Top level of the two-slot priority job scheduler.
//
// in_ch carries items: opcode 0 loads a job into the pending table (sorted
// by priority, then run time), opcode 1 runs one scheduling tick. out_ch
// carries one result transaction per tick and none per load.
// A tick scans the pending table one entry per cycle (each entry is either
// kept or moved out) until it sees the end, then passes through the refill,
// sum, quotient and fix states for backup refill, slot swap and the two
// HHMM adds; the tick result is registered in the fix state. The result
// sits in an output register; the scheduler takes the next item once that
// register is loaded, and a stalled receiver holds the tick in its fix
// state until the register frees.
// Reset empties both tables and both slots and sets the clock to 2400.
`include "assert_macros.svh"
module two_slot_priority_job_scheduler import tps_pkg::*; #(
  parameter int MAX_JOBS     = 16,
  parameter int TICK_MINUTES = 10
) (
  input logic      clk,
  input logic      rst,
  tps_in_if.sink   in_ch,
  tps_out_if.source out_ch
);

  localparam int CW = $clog2(MAX_JOBS + 1);
  localparam int IW = $clog2(MAX_JOBS);

  tps_state_t        state, state_next;
  logic [CW-1:0]     scan_idx, scan_idx_next;
  logic              run_v, run_v_next, rdy_v, rdy_v_next;
  job_t              run_job, run_job_next, rdy_job, rdy_job_next;
  logic [TIME_W-1:0] run_el, run_el_next, rdy_el, rdy_el_next;
  logic [TIME_W-1:0] clk_now, clk_now_next;
  logic [SUM_W-1:0]  sum_c, sum_c_next, sum_e, sum_e_next;
  logic [Q_W-1:0]    q_c, q_c_next, q_e, q_e_next;
  logic              out_v, out_v_next, out_load;

  logic          p_ins, p_del, b_ins, b_del;
  job_t          p_ins_job, b_ins_job, p_rd, b_rd;
  logic [IW-1:0] p_del_idx;
  logic [CW-1:0] p_count, b_count;
  logic          p_full, b_full;

  logic              accept;
  logic [SUM_W-1:0]  r_c, r_e, adj_c, adj_e;
  logic [TIME_W-1:0] new_c, new_e;
  logic              fin;
  logic [PROD_W-1:0] prod_c, prod_e;

  tps_chain #(.DEPTH(MAX_JOBS), .BY_PRIO(1'b1)) u_pend (
    .clk(clk), .rst(rst), .ins(p_ins), .ins_job(p_ins_job), .del(p_del),
    .del_idx(p_del_idx), .rd_idx(scan_idx[IW-1:0]), .rd_job(p_rd),
    .count(p_count), .full(p_full)
  );

  tps_chain #(.DEPTH(MAX_JOBS), .BY_PRIO(1'b0)) u_back (
    .clk(clk), .rst(rst), .ins(b_ins), .ins_job(b_ins_job), .del(b_del),
    .del_idx('0), .rd_idx('0), .rd_job(b_rd),
    .count(b_count), .full(b_full)
  );

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_v;

  assign prod_c = PROD_W'(sum_c) * PROD_W'(RECIP);
  assign prod_e = PROD_W'(sum_e) * PROD_W'(RECIP);
  assign r_c    = sum_c - SUM_W'(SUM_W'(q_c) * SUM_W'(BASE));
  assign r_e    = sum_e - SUM_W'(SUM_W'(q_e) * SUM_W'(BASE));
  assign adj_c  = (r_c >= SUM_W'(MIN_LIM)) ? sum_c + SUM_W'(HOUR_FIX) : sum_c;
  assign adj_e  = (r_e >= SUM_W'(MIN_LIM)) ? sum_e + SUM_W'(HOUR_FIX) : sum_e;
  assign new_c  = adj_c[SUM_W-1] ? TIME_MAX : adj_c[TIME_W-1:0];
  assign new_e  = adj_e[SUM_W-1] ? TIME_MAX : adj_e[TIME_W-1:0];
  assign fin    = run_v && (new_e == TIME_W'(run_job.need));

  always_comb begin
    state_next    = state;
    scan_idx_next = scan_idx;
    run_v_next    = run_v;
    rdy_v_next    = rdy_v;
    run_job_next  = run_job;
    rdy_job_next  = rdy_job;
    run_el_next   = run_el;
    rdy_el_next   = rdy_el;
    clk_now_next  = clk_now;
    sum_c_next    = sum_c;
    sum_e_next    = sum_e;
    q_c_next      = q_c;
    q_e_next      = q_e;
    out_v_next    = out_v && !out_ch.ready;
    out_load      = 1'b0;
    p_ins         = 1'b0;
    p_del         = 1'b0;
    b_ins         = 1'b0;
    b_del         = 1'b0;
    p_ins_job.id     = in_ch.job_id;
    p_ins_job.need   = in_ch.run_time;
    p_ins_job.prio   = in_ch.priority_req;
    p_ins_job.arrive = in_ch.arrival_time;
    b_ins_job     = p_rd;
    p_del_idx     = scan_idx[IW-1:0];

    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.opcode == OP_LOAD) begin
            if (!p_full) begin
              p_ins = 1'b1;
              if (TIME_W'(in_ch.arrival_time) < clk_now) begin
                clk_now_next = TIME_W'(in_ch.arrival_time);
              end
            end
          end else begin
            scan_idx_next = '0;
            state_next    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_idx >= p_count) begin
          state_next = S_REFILL;
        end else if (TIME_W'(p_rd.arrive) > clk_now) begin
          scan_idx_next = scan_idx + CW'(1);
        end else if (!run_v) begin
          run_v_next   = 1'b1;
          run_job_next = p_rd;
          run_el_next  = '0;
          p_del        = 1'b1;
        end else if (!rdy_v) begin
          rdy_v_next   = 1'b1;
          rdy_job_next = p_rd;
          rdy_el_next  = '0;
          p_del        = 1'b1;
        end else if (!b_full) begin
          b_ins = 1'b1;
          p_del = 1'b1;
        end else begin
          scan_idx_next = scan_idx + CW'(1);
        end
      end
      S_REFILL: begin
        if (!rdy_v && (b_count != '0)) begin
          rdy_v_next   = 1'b1;
          rdy_job_next = b_rd;
          rdy_el_next  = '0;
          b_del        = 1'b1;
        end
        state_next = S_SUM;
      end
      S_SUM: begin
        sum_c_next = SUM_W'(clk_now) + SUM_W'(TICK_MINUTES);
        if (run_v && rdy_v && (run_job.prio > rdy_job.prio)) begin
          run_job_next = rdy_job;
          rdy_job_next = run_job;
          run_el_next  = rdy_el;
          rdy_el_next  = run_el;
          sum_e_next   = SUM_W'(rdy_el) + SUM_W'(TICK_MINUTES);
        end else begin
          sum_e_next   = SUM_W'(run_el) + SUM_W'(TICK_MINUTES);
        end
        state_next = S_QUOT;
      end
      S_QUOT: begin
        q_c_next   = Q_W'(prod_c >> RECIP_SH);
        q_e_next   = Q_W'(prod_e >> RECIP_SH);
        state_next = S_FIX;
      end
      S_FIX: begin
        if (!out_v || out_ch.ready) begin
          out_load     = 1'b1;
          out_v_next   = 1'b1;
          clk_now_next = new_c;
          if (run_v) begin
            run_el_next = new_e;
            if (fin) begin
              if (rdy_v) begin
                run_job_next = rdy_job;
                run_el_next  = rdy_el;
                rdy_v_next   = 1'b0;
              end else begin
                run_v_next = 1'b0;
              end
            end
          end
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      run_v   <= 1'b0;
      rdy_v   <= 1'b0;
      clk_now <= CLK_START;
      out_v   <= 1'b0;
    end else begin
      state   <= state_next;
      run_v   <= run_v_next;
      rdy_v   <= rdy_v_next;
      clk_now <= clk_now_next;
      out_v   <= out_v_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    run_job  <= run_job_next;
    rdy_job  <= rdy_job_next;
    run_el   <= run_el_next;
    rdy_el   <= rdy_el_next;
    sum_c    <= sum_c_next;
    sum_e    <= sum_e_next;
    q_c      <= q_c_next;
    q_e      <= q_e_next;
    if (out_load) begin
      out_ch.now_time        <= clk_now;
      out_ch.running_valid   <= run_v;
      out_ch.running_id      <= run_v ? run_job.id : '0;
      out_ch.running_elapsed <= run_v ? new_e : '0;
      out_ch.finished        <= fin;
      out_ch.ready_valid     <= rdy_v_next;
      out_ch.ready_id        <= rdy_v_next ? rdy_job_next.id : '0;
      out_ch.backup_count    <= b_count;
      out_ch.pending_count   <= p_count;
      out_ch.all_done        <= !run_v_next && !rdy_v_next && (b_count == '0) &&
                                (p_count == '0);
    end
  end

  `TPS_ASSERT_IMPL(a_scan_bound, state == S_SCAN, scan_idx <= p_count, "scan index past table")
  `TPS_ASSERT_IMPL(a_backup_feeds, (state == S_IDLE) && (b_count != '0), run_v || rdy_v, "backup held with both slots empty")
  `TPS_ASSERT_NEXT(a_fix_loads, (state == S_FIX) && (!out_v || out_ch.ready), out_v && (state == S_IDLE), "tick result not registered")

endmodule
